[rtl/text_to_integer_parser_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text to integer parser.
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTIP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define TTIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define TTIP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TTIP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/ttip_pkg.sv]
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared constants, types and character decoding for the integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

   localparam int OFFSET_LIMIT = 255;
   localparam int CNT_W        = $clog2(OFFSET_LIMIT + 1);
   localparam int OFFSET_W     = 8;
   localparam int VALUE_W      = 64;
   localparam int RADIX_W      = 6;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_SETTING = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE   = 4'd1;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_X  = 8'h58;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_X  = 8'h78;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;

   localparam logic [7:0] DIGIT_NONE = 8'hFF;
   localparam logic [7:0] LETTER_BASE = 8'd10;

   typedef struct packed {
      logic [RADIX_W-1:0] radix_setting;
      logic               signed_mode;
   } ttip_cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic                negative;
      logic [OFFSET_W-1:0] end_offset;
   } ttip_result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = DIGIT_NONE;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_LC_A) && (c <= CH_LC_Z)) begin
         d = c - CH_LC_A + LETTER_BASE;
      end else if ((c >= CH_UC_A) && (c <= CH_UC_Z)) begin
         d = c - CH_UC_A + LETTER_BASE;
      end
      return d;
   endfunction

   function automatic logic [RADIX_W-1:0] start_radix(input logic [RADIX_W-1:0] s);
      logic [RADIX_W-1:0] r;
      if (s < RADIX_MIN) begin
         r = RADIX_DEC;
      end else if (s > RADIX_MAX) begin
         r = RADIX_MAX;
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

[rtl/ttip_csr.sv]
// ----------------------------------------------------------------------------
// ttip_csr
// Configuration registers: radix setting and signed mode.
// ----------------------------------------------------------------------------
module ttip_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ttip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ttip_pkg::CSR_DATA_W-1:0]  csr_data,
   output ttip_pkg::ttip_cfg_type           cfg
);

   ttip_pkg::ttip_cfg_type cfg_ff;
   ttip_pkg::ttip_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ttip_pkg::CSR_RADIX_SETTING: begin
               cfg_in.radix_setting = csr_data[ttip_pkg::RADIX_W-1:0];
            end
            ttip_pkg::CSR_SIGNED_MODE: begin
               cfg_in.signed_mode = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/ttip_parse.sv]
// ----------------------------------------------------------------------------
// ttip_parse
// Request register and per-character parser state with digit accumulation.
// ----------------------------------------------------------------------------
module ttip_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  ttip_pkg::ttip_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_ch,
   input  logic                    req_first,
   input  logic                    out_ready,
   output logic                    res_vld,
   output ttip_pkg::ttip_result_type res
);

   typedef enum logic [2:0] {
      PH_WS1,
      PH_WS2,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   logic                            in_vld_ff, in_vld_in;
   logic [7:0]                      ch_ff, ch_in;
   logic                            first_ff, first_in;
   phase_type                       phase_ff, phase_in;
   logic [ttip_pkg::VALUE_W-1:0]    acc_ff, acc_in;
   logic [ttip_pkg::RADIX_W-1:0]    radix_ff, radix_in;
   logic                            minus_ff, minus_in;
   logic [ttip_pkg::CNT_W-1:0]      count_ff, count_in;

   phase_type                       phase_eff;
   logic [ttip_pkg::VALUE_W-1:0]    acc_eff;
   logic [ttip_pkg::RADIX_W-1:0]    radix_eff;
   logic                            minus_eff;
   logic [ttip_pkg::CNT_W-1:0]      count_eff;

   logic                            advance;
   logic                            accept;
   logic                            take_digit;
   logic                            consume;
   logic                            emit;
   logic [7:0]                      digit;
   logic [ttip_pkg::VALUE_W-1:0]    product;

   assign advance   = in_vld_ff && out_ready;
   assign req_stall = in_vld_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign digit     = ttip_pkg::digit_of(ch_ff);

   always_comb begin
      in_vld_in = accept || (in_vld_ff && !advance);
      ch_in     = accept ? req_ch : ch_ff;
      first_in  = accept ? req_first : first_ff;
   end

   always_comb begin
      if (first_ff) begin
         phase_eff = PH_WS1;
         acc_eff   = '0;
         radix_eff = ttip_pkg::start_radix(cfg.radix_setting);
         minus_eff = 1'b0;
         count_eff = '0;
      end else begin
         phase_eff = phase_ff;
         acc_eff   = acc_ff;
         radix_eff = radix_ff;
         minus_eff = minus_ff;
         count_eff = count_ff;
      end

      phase_in   = phase_eff;
      acc_in     = acc_eff;
      radix_in   = radix_eff;
      minus_in   = minus_eff;
      take_digit = 1'b0;
      consume    = 1'b0;
      emit       = 1'b0;

      unique case (phase_eff) inside
         PH_WS1, PH_WS2: begin
            if (ttip_pkg::is_space(ch_ff)) begin
               consume = 1'b1;
            end else if ((phase_eff == PH_WS1) && (ch_ff == ttip_pkg::CH_MINUS)
                         && cfg.signed_mode) begin
               minus_in = 1'b1;
               consume  = 1'b1;
               phase_in = PH_WS2;
            end else if (ch_ff == ttip_pkg::CH_ZERO) begin
               consume  = 1'b1;
               phase_in = PH_ZERO;
            end else begin
               phase_in   = PH_DIGITS;
               take_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            phase_in = PH_DIGITS;
            if ((ch_ff == ttip_pkg::CH_LC_X) || (ch_ff == ttip_pkg::CH_UC_X)) begin
               radix_in = ttip_pkg::RADIX_HEX;
               consume  = 1'b1;
            end else begin
               if (cfg.radix_setting < ttip_pkg::RADIX_MIN) begin
                  radix_in = ttip_pkg::RADIX_HEX;
               end
               take_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            take_digit = 1'b1;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      product = acc_eff * {{(ttip_pkg::VALUE_W - ttip_pkg::RADIX_W){1'b0}}, radix_in};

      if (take_digit) begin
         if (digit < {2'b00, radix_in}) begin
            acc_in  = product + {{(ttip_pkg::VALUE_W - 8){1'b0}}, digit};
            consume = 1'b1;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end

      if (consume && (count_eff < ttip_pkg::CNT_W'(ttip_pkg::OFFSET_LIMIT))) begin
         count_in = count_eff + ttip_pkg::CNT_W'(1);
      end else begin
         count_in = count_eff;
      end

      res.value      = minus_eff ? (ttip_pkg::VALUE_W'(0) - acc_eff) : acc_eff;
      res.negative   = minus_eff;
      res.end_offset = ttip_pkg::OFFSET_W'(count_eff);
   end

   assign res_vld = advance && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_WS1;
         acc_ff    <= '0;
         radix_ff  <= ttip_pkg::RADIX_DEC;
         minus_ff  <= 1'b0;
         count_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (advance) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            radix_ff <= radix_in;
            minus_ff <= minus_in;
            count_ff <= count_in;
         end
      end
      ch_ff    <= ch_in;
      first_ff <= first_in;
   end

endmodule

[rtl/ttip_out.sv]
// ----------------------------------------------------------------------------
// ttip_out
// Result register that holds one parsed number until the receiver takes it.
// ----------------------------------------------------------------------------
module ttip_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_vld,
   input  ttip_pkg::ttip_result_type res,
   output logic                      out_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ttip_pkg::ttip_result_type rsp
);

   logic                      vld_ff, vld_in;
   ttip_pkg::ttip_result_type res_ff, res_in;

   assign out_ready = !vld_ff || !rsp_stall;
   assign rsp_valid = vld_ff;
   assign rsp       = res_ff;

   always_comb begin
      vld_in = res_vld || (vld_ff && rsp_stall);
      res_in = res_vld ? res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

endmodule

[rtl/text_to_integer_parser_core.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser_core
// Streaming parser that turns text characters into a 64-bit integer.
// ----------------------------------------------------------------------------
// The request channel carries one character per request, with req_first set
// on the first character of a new string. Leading whitespace, an optional
// minus sign in signed mode and a 0x prefix are handled, then digits are
// accumulated in the selected radix. The first character that is not a digit
// produces one response with the value, the sign flag and the count of
// characters consumed before it; later characters are dropped until the next
// req_first. The csr channel writes the radix setting and signed mode and is
// always ready; it should only be written while the parser is idle.
// A request is registered in the input register and parsed from there into the
// result register that drives rsp_valid; while a stalled response fills the
// result register, the request waits. One request is accepted every cycle
// while req_stall is low; each character passes a single 64x6 multiply-add.
// When rsp_stall holds a waiting response, the parser keeps one more request
// in its input register and then raises req_stall. Reset clears the
// configuration, the parser state and both valid flags.
// ----------------------------------------------------------------------------
`include "text_to_integer_parser_core_assert.svh"

module text_to_integer_parser_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_ch,
   input  logic                             req_first,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ttip_pkg::VALUE_W-1:0]     rsp_value,
   output logic                             rsp_negative,
   output logic [ttip_pkg::OFFSET_W-1:0]    rsp_end_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ttip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ttip_pkg::CSR_DATA_W-1:0]  csr_data
);

   ttip_pkg::ttip_cfg_type    cfg;
   ttip_pkg::ttip_result_type res;
   ttip_pkg::ttip_result_type rsp;
   logic                      res_vld;
   logic                      out_ready;

   ttip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ttip_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_first (req_first),
      .out_ready (out_ready),
      .res_vld   (res_vld),
      .res       (res)
   );

   ttip_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_vld   (res_vld),
      .res       (res),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_value      = rsp.value;
   assign rsp_negative   = rsp.negative;
   assign rsp_end_offset = rsp.end_offset;

   `TTIP_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `TTIP_ASSERT_SAME(a_no_overwrite, clock, reset, res_vld, !rsp_valid || !rsp_stall)
   `TTIP_ASSERT_NEXT(a_drain_empties, clock, reset, rsp_valid && !rsp_stall && !res_vld, !rsp_valid)

endmodule

[tb/text_to_integer_parser_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_core_test
// Self-checking testbench for the streaming text to integer parser.
// ----------------------------------------------------------------------------
// Characters are sent as requests in bursts with random gaps while the
// response side stalls on its own random pattern. A behavioral copy of the
// parser predicts each response when a request is accepted, and every
// response is compared field by field with the oldest prediction. Directed
// strings cover signs, prefixes, flexible radix and ignored characters; long
// strings cover the saturating offset; random strings run under many radix
// and sign settings and a sender pause; a fixed string repeats under a long hold-off.
// ----------------------------------------------------------------------------
module text_to_integer_parser_core_test;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 20;

   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   typedef enum logic [2:0] {
      SKIP_LEAD,
      SKIP_AFTER_SIGN,
      AFTER_ZERO,
      IN_DIGITS,
      FINISHED
   } parse_phase_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_ch = '0;
   logic                             req_first = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [ttip_pkg::VALUE_W-1:0]     rsp_value;
   logic                             rsp_negative;
   logic [ttip_pkg::OFFSET_W-1:0]    rsp_end_offset;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ttip_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ttip_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   logic [ttip_pkg::RADIX_W-1:0]     cfg_radix = '0;
   logic                             cfg_signed = 1'b0;
   parse_phase_type                  p_phase = SKIP_LEAD;
   logic [ttip_pkg::VALUE_W-1:0]     p_acc = '0;
   logic [ttip_pkg::RADIX_W-1:0]     p_radix = ttip_pkg::RADIX_DEC;
   logic                             p_minus = 1'b0;
   int                               p_count = 0;

   ttip_pkg::ttip_result_type        pending_results [$];
   int                               error_count = 0;
   int                               cycle_count = 0;
   int                               items_sent = 0;
   int                               burst_left = 0;
   bit                               sender_gaps = 1'b1;
   bit                               new_string = 1'b0;
   int                               stall_pct = 0;
   int                               stall_run = 0;
   bit                               stall_state = 1'b0;
   int                               hold_cycles = 0;

   text_to_integer_parser_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_negative   (rsp_negative),
      .rsp_end_offset (rsp_end_offset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit char_is_blank(input logic [7:0] c);
      return (c == ttip_pkg::CH_SPACE) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
             (c == 8'h0C) || (c == 8'h0D);
   endfunction

   function automatic int char_digit_value(input logic [7:0] c);
      if ((c >= ttip_pkg::CH_ZERO) && (c <= ttip_pkg::CH_NINE)) begin
         return int'(c - ttip_pkg::CH_ZERO);
      end
      if ((c >= ttip_pkg::CH_LC_A) && (c <= ttip_pkg::CH_LC_Z)) begin
         return int'(c - ttip_pkg::CH_LC_A) + 10;
      end
      if ((c >= ttip_pkg::CH_UC_A) && (c <= ttip_pkg::CH_UC_Z)) begin
         return int'(c - ttip_pkg::CH_UC_A) + 10;
      end
      return 99;
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) begin
         return ttip_pkg::CH_ZERO + 8'(v);
      end
      return ($urandom_range(0, 1) ? ttip_pkg::CH_UC_A : ttip_pkg::CH_LC_A) + 8'(v - 10);
   endfunction

   function automatic void count_char();
      if (p_count < ttip_pkg::OFFSET_LIMIT) begin
         p_count++;
      end
   endfunction

   function automatic void restart_string();
      p_phase = SKIP_LEAD;
      p_acc   = '0;
      p_minus = 1'b0;
      p_count = 0;
      if (cfg_radix < ttip_pkg::RADIX_MIN) begin
         p_radix = ttip_pkg::RADIX_DEC;
      end else if (cfg_radix > ttip_pkg::RADIX_MAX) begin
         p_radix = ttip_pkg::RADIX_MAX;
      end else begin
         p_radix = cfg_radix;
      end
   endfunction

   function automatic bit take_digit(input logic [7:0] c,
                                     output ttip_pkg::ttip_result_type res);
      int d;
      d = char_digit_value(c);
      res = '0;
      if (d < int'(p_radix)) begin
         p_acc = p_acc * {58'd0, p_radix} + 64'(d);
         count_char();
         return 1'b0;
      end
      res.value      = p_minus ? (64'd0 - p_acc) : p_acc;
      res.negative   = p_minus;
      res.end_offset = 8'(p_count);
      p_phase = FINISHED;
      return 1'b1;
   endfunction

   function automatic bit take_prefix(input logic [7:0] c,
                                      output ttip_pkg::ttip_result_type res);
      res = '0;
      if (c == ttip_pkg::CH_ZERO) begin
         count_char();
         p_phase = AFTER_ZERO;
         return 1'b0;
      end
      p_phase = IN_DIGITS;
      return take_digit(c, res);
   endfunction

   function automatic bit advance_parser(input logic [7:0] c, input logic first,
                                         output ttip_pkg::ttip_result_type res);
      bit done;
      done = 1'b0;
      res = '0;
      if (first) begin
         restart_string();
      end
      case (p_phase)
         SKIP_LEAD: begin
            if (char_is_blank(c)) begin
               count_char();
            end else if ((c == ttip_pkg::CH_MINUS) && cfg_signed) begin
               p_minus = 1'b1;
               count_char();
               p_phase = SKIP_AFTER_SIGN;
            end else begin
               done = take_prefix(c, res);
            end
         end
         SKIP_AFTER_SIGN: begin
            if (char_is_blank(c)) begin
               count_char();
            end else begin
               done = take_prefix(c, res);
            end
         end
         AFTER_ZERO: begin
            if ((c == ttip_pkg::CH_LC_X) || (c == ttip_pkg::CH_UC_X)) begin
               p_radix = ttip_pkg::RADIX_HEX;
               count_char();
               p_phase = IN_DIGITS;
            end else begin
               if (cfg_radix < ttip_pkg::RADIX_MIN) begin
                  p_radix = ttip_pkg::RADIX_HEX;
               end
               p_phase = IN_DIGITS;
               done = take_digit(c, res);
            end
         end
         IN_DIGITS: begin
            done = take_digit(c, res);
         end
         default: begin
            p_phase = FINISHED;
         end
      endcase
      return done;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %0s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic send_char(input logic [7:0] c, input logic first);
      ttip_pkg::ttip_result_type predicted;
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_ch    <= c;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      if (advance_parser(c, first, predicted)) begin
         pending_results.push_back(predicted);
      end
      items_sent++;
   endtask

   task automatic send_next(input logic [7:0] c);
      send_char(c, new_string);
      new_string = 1'b0;
   endtask

   task automatic send_text(input string s);
      new_string = 1'b1;
      for (int i = 0; i < s.len(); i++) begin
         send_next(8'(s[i]));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [ttip_pkg::RADIX_W-1:0] radix,
                             input logic signed_on);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= ttip_pkg::CSR_RADIX_SETTING;
      csr_data  <= ttip_pkg::CSR_DATA_W'(radix);
      do @(posedge clock); while (!csr_ready);
      cfg_radix = radix;
      csr_index <= ttip_pkg::CSR_SIGNED_MODE;
      csr_data  <= ttip_pkg::CSR_DATA_W'(signed_on);
      do @(posedge clock); while (!csr_ready);
      cfg_signed = signed_on;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_string();
      int n;
      int eff_radix;
      logic [7:0] c;
      new_string = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            send_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 9) == 0));
         end
         return;
      end
      if (cfg_radix < ttip_pkg::RADIX_MIN) begin
         eff_radix = 10;
      end else if (cfg_radix > ttip_pkg::RADIX_MAX) begin
         eff_radix = 36;
      end else begin
         eff_radix = int'(cfg_radix);
      end
      repeat ($urandom_range(0, 3)) send_next(BLANKS[3'($urandom_range(0, 5))]);
      if ($urandom_range(0, 2) == 0) begin
         send_next(ttip_pkg::CH_MINUS);
         repeat ($urandom_range(0, 2)) send_next(BLANKS[3'($urandom_range(0, 5))]);
      end
      case ($urandom_range(0, 3))
         0: begin
            send_next(ttip_pkg::CH_ZERO);
            send_next($urandom_range(0, 1) ? ttip_pkg::CH_UC_X : ttip_pkg::CH_LC_X);
            eff_radix = 16;
         end
         1: begin
            send_next(ttip_pkg::CH_ZERO);
            if (cfg_radix < ttip_pkg::RADIX_MIN) begin
               eff_radix = 16;
            end
         end
         default: begin
         end
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
      repeat (n) send_next(digit_char($urandom_range(0, eff_radix - 1)));
      do c = 8'($urandom_range(0, 255)); while (char_digit_value(c) < eff_radix);
      send_next(c);
      repeat ($urandom_range(0, 2)) send_next(8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      set_config(6'd0, 1'b1);
      send_text("\t-12;");
      send_char(8'hFF, 1'b0);
      send_text("0xg");
      send_text("017");
      send_char(8'h00, 1'b0);
      send_text("- !");
      send_text("0X1fz");
      drain_results();
   endtask

   task automatic test_offset_saturation();
      set_config(6'd10, 1'b0);
      new_string = 1'b1;
      repeat (250) send_next(BLANKS[3'($urandom_range(0, 5))]);
      repeat (10) send_next(digit_char($urandom_range(0, 9)));
      send_next(8'h2C);
      drain_results();
   endtask

   task automatic test_random_configs();
      logic [ttip_pkg::RADIX_W-1:0] radix_list [8];
      logic                         signed_list [8];
      int                           phase_start;
      radix_list  = '{6'd0, 6'd2, 6'd36, 6'd63, 6'd1, 6'd10, 6'd16, 6'd37};
      signed_list = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      for (int p = 0; p < 10; p++) begin
         if (p < 8) begin
            set_config(radix_list[3'(p)], signed_list[3'(p)]);
         end else begin
            set_config(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         end
         case (p % 4)
            0: begin
               sender_gaps = 1'b1;
               stall_pct = 30;
            end
            1: begin
               sender_gaps = 1'b0;
               stall_pct = 0;
            end
            2: begin
               sender_gaps = 1'b1;
               stall_pct = 70;
            end
            default: begin
               sender_gaps = 1'b0;
               stall_pct = 50;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_string();
      end
      drain_results();
   endtask

   task automatic test_response_backpressure();
      set_config(6'd0, 1'b1);
      sender_gaps = 1'b0;
      stall_pct = 0;
      hold_cycles = 150;
      repeat (15) begin
         send_text("-42 ");
      end
      drain_results();
   endtask

   task automatic test_sender_pause();
      sender_gaps = 1'b1;
      stall_pct = 40;
      repeat (4) send_random_string();
      drain_results();
      repeat (4) send_random_string();
      drain_results();
   endtask

   always @(posedge clock) begin : drive_rsp_stall
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_state = ($urandom_range(1, 100) <= stall_pct);
            stall_run = $urandom_range(1, 8);
         end
         stall_run = stall_run - 1;
         rsp_stall <= stall_state;
      end
   end

   always @(posedge clock) begin : check_responses
      ttip_pkg::ttip_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with none pending", rsp_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value) begin
               report_mismatch("value", rsp_value, want.value);
            end
            if (rsp_negative !== want.negative) begin
               report_mismatch("negative", 64'(rsp_negative), 64'(want.negative));
            end
            if (rsp_end_offset !== want.end_offset) begin
               report_mismatch("end_offset", 64'(rsp_end_offset), 64'(want.end_offset));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_to_integer_parser_core verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_offset_saturation();
      test_random_configs();
      test_response_backpressure();
      test_sender_pause();
      drain_results();
      if (error_count == 0) begin
         $display("text_to_integer_parser_core verification clean");
      end else begin
         $display("text_to_integer_parser_core verification failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/ttip_pkg.sv
rtl/ttip_csr.sv
rtl/ttip_parse.sv
rtl/ttip_out.sv
rtl/text_to_integer_parser_core.sv
tb/text_to_integer_parser_core_test.sv
